FILE: hdl/rmff_pkg.sv
// rmff_pkg: sizes, operation and status codes, and the command and status
// structs shared by the region map allocator controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps
package rmff_pkg;

	localparam int NUM_HOSTS   = 4;
	localparam int MAX_REGIONS = 16;

	localparam int ADDR_IN_W  = 32;
	localparam int DEPTH      = NUM_HOSTS * MAX_REGIONS;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W      = $clog2(MAX_REGIONS);
	localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
	localparam int HOST_IDX_W = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;
	localparam int ENTRY_W    = 2 * ADDR_IN_W;

	localparam int OP_W       = 2;
	localparam int HOST_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int IN_TDATA_W = 2 * ADDR_IN_W;
	localparam int IN_TUSER_W = OP_W + HOST_W;
	localparam int OUT_BITS   = STATUS_W + ADDR_IN_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_BITS;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_FIND   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_OVERLAP  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    cp_init;
		logic    cp_rd;
		logic    put;
		logic    done;
		status_t code;
		logic    cnt_inc;
		logic    cnt_dec;
	} rmff_cmd_t;

	typedef struct packed {
		op_t  op;
		logic host_ok;
		logic n_zero;
		logic n_full;
		logic scan_end;
		logic hit;
		logic ovl;
		logic shift_ins;
		logic shift_era;
		logic cp_last;
		logic out_free;
	} rmff_stat_t;

endpackage

FILE: hdl/rmff_ram.sv
// rmff_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
`timescale 1ns / 1ps
module rmff_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/rmff_dp.sv
// rmff_dp: datapath of the region map allocator: request registers, per-host
// region counts, region store, list scan, entry shifting and the result register.
// Depends on rmff_pkg and rmff_ram.
`timescale 1ns / 1ps
module rmff_dp import rmff_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  op_t                  in_op,
	input  logic [HOST_W-1:0]    in_host,
	input  logic [ADDR_IN_W-1:0] in_start,
	input  logic [ADDR_IN_W-1:0] in_size,
	input  rmff_cmd_t            cmd,
	output rmff_stat_t           stat,
	input  logic                 m_tready,
	output logic                 out_valid,
	output status_t              out_status,
	output logic [ADDR_IN_W-1:0] out_free_start
);

	op_t                  op_q;
	logic                 host_ok_q;
	logic [HOST_IDX_W-1:0] hidx_q;
	logic [ADDR_W-1:0]    base_q;
	logic [ADDR_IN_W-1:0] start_q;
	logic [ADDR_IN_W-1:0] size_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     cnt_q [NUM_HOSTS];

	logic [CNT_W-1:0]     rd_idx_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 hit_q;
	logic                 ovl_q;
	logic [ADDR_IN_W:0]   prev_end_q;
	logic [ADDR_IN_W:0]   res_q;
	logic                 ev_vld_s1;
	logic [CNT_W-1:0]     ev_idx_s1;
	logic                 cp_vld_s1;
	logic [IDX_W-1:0]     cp_dst_s1;
	logic                 m_tvalid_q;
	status_t              status_q;
	logic [ADDR_IN_W-1:0] fs_q;

	logic [ENTRY_W-1:0]   rdata;
	logic [ADDR_IN_W-1:0] ent_start;
	logic [ADDR_IN_W-1:0] ent_len;
	logic [ADDR_IN_W:0]   ent_end;
	logic [ADDR_IN_W:0]   req_end;
	logic [ADDR_IN_W+1:0] gap;
	logic [CNT_W-1:0]     n_last;
	logic                 issue;
	logic                 eval;
	logic                 last_now;
	logic                 hit_now;
	logic                 ovl_hit;
	logic                 in_host_ok;
	logic [HOST_IDX_W-1:0] in_hidx;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [ENTRY_W-1:0]   wdata;
	logic [ADDR_W-1:0]    raddr;
	logic                 out_free;

	assign in_host_ok = 32'(in_host) < 32'(NUM_HOSTS);
	assign in_hidx    = HOST_IDX_W'(in_host);

	assign ent_start = rdata[ENTRY_W-1:ADDR_IN_W];
	assign ent_len   = rdata[ADDR_IN_W-1:0];
	assign ent_end   = {1'b0, ent_start} + {1'b0, ent_len};
	assign req_end   = {1'b0, start_q} + {1'b0, size_q};
	assign gap       = {2'b00, ent_start} - {1'b0, prev_end_q};
	assign n_last    = n_q - CNT_W'(1);

	assign issue    = cmd.scan && (rd_idx_q < n_q);
	assign eval     = cmd.scan && ev_vld_s1;
	assign last_now = ev_idx_s1 == n_last;
	assign ovl_hit  = (req_end > {1'b0, ent_start}) ||
		((ev_idx_s1 != '0) && (prev_end_q > {1'b0, start_q}));

	always_comb begin
		case (op_q)
			OP_INSERT: hit_now = ent_start > start_q;
			OP_ERASE:  hit_now = (ent_start == start_q) && (ent_len == size_q);
			OP_FIND:   hit_now = (ev_idx_s1 != '0) && ((size_q == '0) ||
				(!gap[ADDR_IN_W+1] && (gap[ADDR_IN_W:0] >= {1'b0, size_q})));
			default:   hit_now = 1'b0;
		endcase
	end

	// region store: start in the upper half, length in the lower half
	assign raddr = base_q + ADDR_W'(rd_idx_q[IDX_W-1:0]);
	assign we    = cmd.put || cp_vld_s1;
	assign waddr = cmd.put ? base_q + ADDR_W'(pos_q[IDX_W-1:0]) : base_q + ADDR_W'(cp_dst_s1);
	assign wdata = cmd.put ? {start_q, size_q} : rdata;

	rmff_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_op;
			host_ok_q <= in_host_ok;
			hidx_q    <= in_hidx;
			base_q    <= ADDR_W'(32'(in_host) * MAX_REGIONS);
			start_q   <= in_start;
			size_q    <= in_size;
			n_q       <= in_host_ok ? cnt_q[in_hidx] : '0;
			rd_idx_q  <= '0;
			pos_q     <= '0;
			hit_q     <= 1'b0;
			ovl_q     <= 1'b0;
			res_q     <= '0;
		end else if (cmd.scan) begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (eval) begin
				prev_end_q <= ent_end;
				if (hit_now) begin
					hit_q <= 1'b1;
					pos_q <= ev_idx_s1;
					ovl_q <= ovl_hit;
					res_q <= prev_end_q;
				end else if (last_now) begin
					pos_q <= n_q;
					ovl_q <= ent_end > {1'b0, start_q};
					res_q <= ent_end;
				end
			end
		end else if (cmd.cp_init) begin
			rd_idx_q <= (op_q == OP_INSERT) ? n_last : pos_q + CNT_W'(1);
		end else if (cmd.cp_rd) begin
			rd_idx_q <= (op_q == OP_INSERT) ? rd_idx_q - CNT_W'(1) : rd_idx_q + CNT_W'(1);
		end
		ev_idx_s1 <= rd_idx_q;
		cp_dst_s1 <= (op_q == OP_INSERT) ? rd_idx_q[IDX_W-1:0] + IDX_W'(1)
			: rd_idx_q[IDX_W-1:0] - IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_vld_s1 <= 1'b0;
			cp_vld_s1 <= 1'b0;
		end else begin
			ev_vld_s1 <= issue;
			cp_vld_s1 <= cmd.cp_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOSTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.done) begin
			if (cmd.cnt_inc) begin
				cnt_q[hidx_q] <= n_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q[hidx_q] <= n_last;
			end
		end
	end

	// result register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			status_q <= cmd.code;
			if (op_q != OP_FIND) begin
				fs_q <= '0;
			end else begin
				fs_q <= res_q[ADDR_IN_W] ? '1 : res_q[ADDR_IN_W-1:0];
			end
		end
	end

	assign out_valid      = m_tvalid_q;
	assign out_status     = status_q;
	assign out_free_start = fs_q;

	assign stat.op        = op_q;
	assign stat.host_ok   = host_ok_q;
	assign stat.n_zero    = n_q == '0;
	assign stat.n_full    = n_q >= CNT_W'(MAX_REGIONS);
	assign stat.scan_end  = eval && (hit_now || last_now);
	assign stat.hit       = hit_q;
	assign stat.ovl       = ovl_q;
	assign stat.shift_ins = pos_q < n_q;
	assign stat.shift_era = ({1'b0, pos_q} + (CNT_W+1)'(1)) < {1'b0, n_q};
	assign stat.cp_last   = (op_q == OP_INSERT) ? (rd_idx_q == pos_q) : (rd_idx_q == n_last);
	assign stat.out_free  = out_free;

	a_put_no_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !cp_vld_s1)
		else $error("new entry write collides with a shift write");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> out_free)
		else $error("result loaded while previous result still held");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.done && cmd.cnt_inc) |-> (n_q < CNT_W'(MAX_REGIONS)))
		else $error("region count would exceed table size");

endmodule

FILE: hdl/rmff_ctrl.sv
// rmff_ctrl: controller state machine of the region map allocator; sequences
// scan, shift, write and result steps. Depends on rmff_pkg.
`timescale 1ns / 1ps
module rmff_ctrl import rmff_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  rmff_stat_t stat,
	output rmff_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_SETTLE = 7'b0010000,
		S_PUT    = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    inc_q, inc_d;
	logic    dec_q, dec_d;

	always_comb begin
		state_d     = state_q;
		code_d      = code_q;
		inc_d       = inc_q;
		dec_d       = dec_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.code    = code_q;
		cmd.cnt_inc = inc_q;
		cmd.cnt_dec = dec_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					code_d   = ST_OK;
					inc_d    = 1'b0;
					dec_d    = 1'b0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.n_zero || stat.op == OP_NONE) begin
					state_d = S_DECIDE;
				end else begin
					cmd.scan = 1'b1;
					if (stat.scan_end) begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				state_d = S_FIN;
				case (stat.op)
					OP_INSERT: begin
						if (!stat.host_ok) begin
							code_d = ST_FULL;
						end else if (stat.n_zero) begin
							inc_d   = 1'b1;
							state_d = S_PUT;
						end else if (stat.ovl) begin
							code_d = ST_OVERLAP;
						end else if (stat.n_full) begin
							code_d = ST_FULL;
						end else begin
							inc_d = 1'b1;
							if (stat.shift_ins) begin
								cmd.cp_init = 1'b1;
								state_d     = S_SHIFT;
							end else begin
								state_d = S_PUT;
							end
						end
					end
					OP_ERASE: begin
						if (stat.n_zero) begin
							code_d = ST_EMPTY;
						end else if (!stat.hit) begin
							code_d = ST_NOTFOUND;
						end else begin
							dec_d = 1'b1;
							if (stat.shift_era) begin
								cmd.cp_init = 1'b1;
								state_d     = S_SHIFT;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				cmd.cp_rd = 1'b1;
				if (stat.cp_last) begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				state_d = inc_q ? S_PUT : S_FIN;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
			inc_q   <= 1'b0;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			inc_q   <= inc_d;
			dec_q   <= dec_d;
		end
	end

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.done && (cmd.cnt_inc || cmd.cnt_dec)) |-> (cmd.code == ST_OK))
		else $error("region count changed on a failed request");

	a_count_one_way: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> !(cmd.cnt_inc && cmd.cnt_dec))
		else $error("region count both raised and lowered");

	a_put_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (inc_q && stat.op == OP_INSERT))
		else $error("entry write outside a successful insert");

endmodule

FILE: hdl/region_map_first_fit_allocator.sv
// region_map_first_fit_allocator: top level of the per-host sorted region map
// with insert, erase and first-fit search. Depends on rmff_pkg, rmff_ctrl, rmff_dp.
//
// channel  dir  signals                     content
// s        in   tvalid tready tdata tuser   request: tuser op, host_id; tdata start, size
// m        out  tvalid tready tdata         result: status, free_start
//
// one request at a time; n is the host's region count
// insert and erase run a list scan, then a shift of the store
// find free runs the list scan only, bounded by the one read port of the store
// a result waits in an output register; the next request is taken meanwhile
// reset clears all region counts at once; the store itself is not cleared
`timescale 1ns / 1ps
module region_map_first_fit_allocator import rmff_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // region_start, region_size
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // op, host_id
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // status, free_start, zero pad
);

	rmff_cmd_t            cmd;
	rmff_stat_t           stat;
	status_t              out_status;
	logic [ADDR_IN_W-1:0] out_free_start;

	rmff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmff_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_op          (op_t'(s_tuser[OP_W-1:0])),
		.in_host        (s_tuser[IN_TUSER_W-1:OP_W]),
		.in_start       (s_tdata[ADDR_IN_W-1:0]),
		.in_size        (s_tdata[IN_TDATA_W-1:ADDR_IN_W]),
		.cmd            (cmd),
		.stat           (stat),
		.m_tready       (m_tready),
		.out_valid      (m_tvalid),
		.out_status     (out_status),
		.out_free_start (out_free_start)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_free_start, out_status};

endmodule

FILE: tb/region_map_first_fit_allocator_tb.sv
// region_map_first_fit_allocator_tb: self-checking bench for the per-host region map
// with insert, erase and first-fit search; predicts each result in-line and checks it.
// Depends on rmff_pkg and region_map_first_fit_allocator.
`timescale 1ns / 1ps
module region_map_first_fit_allocator_tb;
	import rmff_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 64;

	typedef struct packed {
		status_t         status;
		logic [31:0]     free_start;
	} region_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // region_start, region_size
	logic [IN_TUSER_W-1:0]  s_tuser = '0;   // op, host_id
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // status, free_start, zero pad

	logic [31:0]    map_start [NUM_HOSTS][MAX_REGIONS];
	logic [31:0]    map_len   [NUM_HOSTS][MAX_REGIONS];
	int             map_count [NUM_HOSTS];
	region_result_t pending_results [$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	bit long_hold_req = 1'b0;

	region_map_first_fit_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic status_t map_insert(int h, logic [31:0] s, logic [31:0] len);
		int n;
		int pos;
		n = map_count[h];
		pos = 0;
		if (n > 0) begin
			while (pos < n && map_start[h][pos] <= s)
				pos++;
			if (pos < n && {1'b0, s} + {1'b0, len} > {1'b0, map_start[h][pos]})
				return ST_OVERLAP;
			if (pos > 0 && {1'b0, map_start[h][pos-1]} + {1'b0, map_len[h][pos-1]} > {1'b0, s})
				return ST_OVERLAP;
			if (n >= MAX_REGIONS)
				return ST_FULL;
		end
		for (int i = n; i > pos; i--) begin
			map_start[h][i] = map_start[h][i-1];
			map_len[h][i]   = map_len[h][i-1];
		end
		map_start[h][pos] = s;
		map_len[h][pos]   = len;
		map_count[h]      = n + 1;
		return ST_OK;
	endfunction

	function automatic status_t map_erase(int h, logic [31:0] s, logic [31:0] len);
		int n;
		int pos;
		n = map_count[h];
		pos = 0;
		if (n == 0)
			return ST_EMPTY;
		while (pos < n && !(map_start[h][pos] == s && map_len[h][pos] == len))
			pos++;
		if (pos == n)
			return ST_NOTFOUND;
		for (int i = pos; i + 1 < n; i++) begin
			map_start[h][i] = map_start[h][i+1];
			map_len[h][i]   = map_len[h][i+1];
		end
		map_count[h] = n - 1;
		return ST_OK;
	endfunction

	function automatic logic [31:0] map_find(int h, logic [31:0] want);
		logic [32:0] res;
		logic [32:0] gap_at;
		logic [32:0] nxt;
		logic [32:0] gap;
		res = '0;
		for (int i = 0; i < map_count[h]; i++) begin
			gap_at = {1'b0, map_start[h][i]} + {1'b0, map_len[h][i]};
			res = gap_at;
			if (i + 1 < map_count[h]) begin
				nxt = {1'b0, map_start[h][i+1]};
				gap = (nxt >= gap_at) ? nxt - gap_at : '0;
				if (gap >= {1'b0, want})
					break;
			end
		end
		return res[32] ? 32'hFFFF_FFFF : res[31:0];
	endfunction

	function automatic region_result_t predict_region_op(op_t op, logic [1:0] host,
			logic [31:0] start, logic [31:0] size);
		region_result_t r;
		r.status = ST_OK;
		r.free_start = '0;
		case (op)
			OP_INSERT: r.status = map_insert(host, start, size);
			OP_ERASE:  r.status = map_erase(host, start, size);
			OP_FIND:   r.free_start = map_find(host, size);
			default: ;
		endcase
		return r;
	endfunction

	task automatic issue_request(op_t op, logic [1:0] host, logic [31:0] start,
			logic [31:0] size);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {size, start};
		s_tuser  <= {host, op};
		do @(posedge clk); while (!s_tready);
		pending_results = {pending_results, predict_region_op(op, host, start, size)};
	endtask

	function automatic logic [31:0] pick_start();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 31) * 128 + $urandom_range(0, 3) * 32;
			6, 7:             return 32'hFFFF_F000 + $urandom_range(0, 4095);
			default:          return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 3) * 32 + $urandom_range(0, 31);
			6:                return 32'h0;
			7, 8:             return $urandom_range(0, 4096);
			default:          return $urandom;
		endcase
	endfunction

	// result stream receiver: short random stalls plus one long hold on demand
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		region_result_t got;
		region_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status     = status_t'(m_tdata[STATUS_W-1:0]);
			got.free_start = m_tdata[STATUS_W +: ADDR_IN_W];
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d free_start %h", got.status,
					got.free_start);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.free_start !== want.free_start) begin
					$error("free_start: expected %h actual %h", want.free_start,
						got.free_start);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_directed();
		issue_request(OP_FIND,   2'd0, 32'h0,         32'h0);
		issue_request(OP_ERASE,  2'd0, 32'h100,       32'h100);
		issue_request(OP_NONE,   2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(OP_INSERT, 2'd0, 32'h100,       32'h100);
		issue_request(OP_INSERT, 2'd0, 32'h100,       32'h0);
		issue_request(OP_INSERT, 2'd0, 32'h300,       32'h100);
		issue_request(OP_INSERT, 2'd0, 32'h1F0,       32'h20);
		issue_request(OP_INSERT, 2'd0, 32'h250,       32'h100);
		issue_request(OP_INSERT, 2'd0, 32'h200,       32'h100);
		issue_request(OP_FIND,   2'd0, 32'h0,         32'h0);
		issue_request(OP_ERASE,  2'd0, 32'h200,       32'h100);
		issue_request(OP_FIND,   2'd0, 32'hFFFF_FFFF, 32'h100);
		issue_request(OP_FIND,   2'd0, 32'h0,         32'h101);
		issue_request(OP_ERASE,  2'd0, 32'h300,       32'h50);
		issue_request(OP_ERASE,  2'd0, 32'h300,       32'h100);
		// regions reaching past the 32-bit range
		issue_request(OP_INSERT, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(OP_INSERT, 2'd1, 32'h0,         32'hFFFF_FFFF);
		issue_request(OP_FIND,   2'd1, 32'h0,         32'hFFFF_FFFF);
		issue_request(OP_INSERT, 2'd1, 32'h8000_0000, 32'h1);
		// equal starts keep arrival order
		issue_request(OP_INSERT, 2'd2, 32'h1000,      32'h0);
		issue_request(OP_INSERT, 2'd2, 32'h1000,      32'h0);
		issue_request(OP_INSERT, 2'd2, 32'h1000,      32'h10);
		issue_request(OP_ERASE,  2'd2, 32'h1000,      32'h10);
		issue_request(OP_ERASE,  2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(OP_FIND,   2'd3, 32'h0,         32'hFFFF_FFFF);
	endtask

	task automatic test_table_full();
		int k;
		for (int i = MAX_REGIONS - 1; i >= 0; i--)
			issue_request(OP_INSERT, 2'd3, i * 32'h1000 + $urandom_range(0, 255),
				$urandom_range(1, 32'hE00));
		issue_request(OP_INSERT, 2'd3, 32'h0010_0000, 32'h10);
		issue_request(OP_INSERT, 2'd3, map_start[3][0], 32'h1);
		issue_request(OP_ERASE,  2'd3, map_start[3][5], map_len[3][5] + 1);
		issue_request(OP_FIND,   2'd3, $urandom, 32'h0);
		issue_request(OP_FIND,   2'd3, $urandom, 32'h800);
		issue_request(OP_FIND,   2'd3, $urandom, 32'hFFFF_FFFF);
		while (map_count[3] > 0) begin
			k = $urandom_range(0, map_count[3] - 1);
			issue_request(OP_ERASE, 2'd3, map_start[3][k], map_len[3][k]);
		end
		issue_request(OP_FIND, 2'd3, $urandom, $urandom);
	endtask

	task automatic test_output_backpressure();
		src_gaps = 1'b0;
		long_hold_req = 1'b1;
		for (int i = 0; i < 14; i++) begin
			if (i % 3 == 2)
				issue_request(OP_FIND, 2'd0, $urandom, i * 8);
			else
				issue_request(OP_INSERT, 2'd0, 32'h8000 + i * 32'h40, 32'h20);
		end
		src_gaps = 1'b1;
	endtask

	task automatic test_random_traffic(int count);
		int r;
		int k;
		logic [1:0] host;
		for (int i = 0; i < count; i++) begin
			if (i == count - 150) begin
				src_gaps = 1'b0;
				sink_gaps = 1'b0;
			end
			host = $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				issue_request(OP_INSERT, host, pick_start(), pick_size());
			end else if (r < 70) begin
				if (map_count[host] > 0 && $urandom_range(0, 3) != 0) begin
					k = $urandom_range(0, map_count[host] - 1);
					issue_request(OP_ERASE, host, map_start[host][k], map_len[host][k]);
				end else begin
					issue_request(OP_ERASE, host, pick_start(), pick_size());
				end
			end else if (r < 95) begin
				issue_request(OP_FIND, host, $urandom, pick_size());
			end else begin
				issue_request(OP_NONE, host, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_output_backpressure();
		test_random_traffic(820);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rmff_pkg.sv
hdl/rmff_ram.sv
hdl/rmff_dp.sv
hdl/rmff_ctrl.sv
hdl/region_map_first_fit_allocator.sv
tb/region_map_first_fit_allocator_tb.sv
